### hdl/bddc_pkg.sv
package bddc_pkg;

  typedef struct packed {
    logic load;       // take a new transaction into the working registers
    logic div_clr;    // clear remainders before a digit division
    logic div_step;   // one restoring-division bit on both values
    logic mul_lo;     // multiply against the low half of the prefix product
    logic mul_hi;     // multiply against the high half, add into the accumulator
    logic mul_bound;  // multiplicand is bound digit + 1 (else query digit)
    logic commit_f;   // running count from the accumulator, if digit in range
    logic commit_p;   // prefix product from the accumulator, handle violation
    logic capture;    // load the result registers
  } bddc_cmd_t;

  typedef struct packed {
    logic vals_zero;  // both remaining values are zero
  } bddc_status_t;

endpackage

### hdl/bddc_datapath.sv
module bddc_datapath #(
  parameter int VALUE_BITS = 63,
  parameter int BASE_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      base_wr_en,
  input  logic [BASE_BITS-1:0]      base_wr_data,
  input  logic [VALUE_BITS-1:0]     query_value,
  input  logic [VALUE_BITS-1:0]     bound_value,
  input  bddc_pkg::bddc_cmd_t       cmd,
  output bddc_pkg::bddc_status_t    status,
  output logic [63:0]               dominated_count,
  output logic [62:0]               undominated_count,
  output logic                      query_dominated
);
  import bddc_pkg::*;

  localparam int PW = BASE_BITS + 33;

  logic [BASE_BITS-1:0]  base_r;
  logic [VALUE_BITS-1:0] rq;
  logic [VALUE_BITS-1:0] rb;
  logic [VALUE_BITS-1:0] low_val;
  logic [BASE_BITS-1:0]  rem_q;
  logic [BASE_BITS-1:0]  rem_b;
  logic [63:0]           prefix_product;
  logic [63:0]           running_count;
  logic [63:0]           acc;
  logic                  viol;

  logic [BASE_BITS:0]    rem_sh_q;
  logic [BASE_BITS:0]    rem_sh_b;
  logic                  ge_q;
  logic                  ge_b;
  logic [BASE_BITS:0]    mul_a;
  logic [31:0]           mul_b;
  logic [PW-1:0]         prod;
  logic [63:0]           prod64;
  logic                  digit_over;

  // restoring division, one quotient bit per cycle, quotient shifts into rq/rb
  assign rem_sh_q = {rem_q, rq[VALUE_BITS-1]};
  assign rem_sh_b = {rem_b, rb[VALUE_BITS-1]};
  assign ge_q     = rem_sh_q >= {1'b0, base_r};
  assign ge_b     = rem_sh_b >= {1'b0, base_r};

  assign mul_a  = cmd.mul_bound ? ({1'b0, rem_b} + (BASE_BITS+1)'(1)) : {1'b0, rem_q};
  assign mul_b  = cmd.mul_hi ? prefix_product[63:32] : prefix_product[31:0];
  assign prod   = PW'(mul_a) * PW'(mul_b);
  assign prod64 = 64'(prod);

  assign digit_over = rem_q > rem_b;

  assign status.vals_zero = (rq == '0) && (rb == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_r <= BASE_BITS'(2);
    end else if (base_wr_en) begin
      // radix below two behaves as two
      if (base_wr_data[BASE_BITS-1:1] == '0) begin
        base_r <= BASE_BITS'(2);
      end else begin
        base_r <= base_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rq             <= query_value;
      rb             <= bound_value;
      low_val        <= (query_value < bound_value) ? query_value : bound_value;
      prefix_product <= 64'd1;
      running_count  <= 64'd1;
      viol           <= 1'b0;
    end
    if (cmd.div_clr) begin
      rem_q <= '0;
      rem_b <= '0;
    end
    if (cmd.div_step) begin
      rem_q <= ge_q ? BASE_BITS'(rem_sh_q - {1'b0, base_r}) : BASE_BITS'(rem_sh_q);
      rem_b <= ge_b ? BASE_BITS'(rem_sh_b - {1'b0, base_r}) : BASE_BITS'(rem_sh_b);
      rq    <= {rq[VALUE_BITS-2:0], ge_q};
      rb    <= {rb[VALUE_BITS-2:0], ge_b};
    end
    if (cmd.mul_lo) begin
      acc <= prod64 + (cmd.mul_bound ? 64'd0 : running_count);
    end
    if (cmd.mul_hi) begin
      acc <= acc + {prod64[31:0], 32'd0};
    end
    if (cmd.commit_f && !digit_over) begin
      running_count <= acc;
    end
    if (cmd.commit_p) begin
      prefix_product <= acc;
      if (digit_over) begin
        running_count <= acc;
        viol          <= 1'b1;
      end
    end
    if (cmd.capture) begin
      dominated_count   <= running_count;
      undominated_count <= 63'(64'(low_val) + 64'd1 - running_count);
      query_dominated   <= !viol;
    end
  end

endmodule

### hdl/bddc_ctrl.sv
module bddc_ctrl #(
  parameter int VALUE_BITS = 63
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  bddc_pkg::bddc_status_t status,
  output bddc_pkg::bddc_cmd_t    cmd
);
  import bddc_pkg::*;

  localparam int CW = $clog2(VALUE_BITS);
  localparam logic [CW-1:0] LAST_BIT = CW'(VALUE_BITS - 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_M1LO  = 9'b000001000,
    S_M1HI  = 9'b000010000,
    S_FUPD  = 9'b000100000,
    S_M2LO  = 9'b001000000,
    S_M2HI  = 9'b010000000,
    S_PUPD  = 9'b100000000
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.vals_zero) begin
          // result slot must be free before it is overwritten
          if (!out_valid || out_ready) begin
            cmd.capture    = 1'b1;
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          cmd.div_clr = 1'b1;
          cnt_next    = '0;
          state_next  = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CW'(1);
        if (cnt == LAST_BIT) begin
          state_next = S_M1LO;
        end
      end
      S_M1LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_M1HI;
      end
      S_M1HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_FUPD;
      end
      S_FUPD: begin
        cmd.commit_f = 1'b1;
        state_next   = S_M2LO;
      end
      S_M2LO: begin
        cmd.mul_lo    = 1'b1;
        cmd.mul_bound = 1'b1;
        state_next    = S_M2HI;
      end
      S_M2HI: begin
        cmd.mul_hi    = 1'b1;
        cmd.mul_bound = 1'b1;
        state_next    = S_PUPD;
      end
      S_PUPD: begin
        cmd.commit_p = 1'b1;
        state_next   = S_CHECK;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  a_onehot_state: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state not one-hot");

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CHECK))
    else $error("accepted transaction did not start a walk");

  a_capture_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

  a_capture_result: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (out_valid && state == S_IDLE))
    else $error("capture did not present a result");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == LAST_BIT) |=> (state == S_M1LO))
    else $error("division did not end after the last bit");
`endif

endmodule

### hdl/base_digit_dominance_counter.sv
// Base digit dominance counter.
// Input channel (in_valid/in_ready) carries query_value n and bound_value m;
// output channel (out_valid/out_ready) returns dominated_count,
// undominated_count and query_dominated, one result per input transaction.
// digit_base is written with digit_base_wr_en; the user must write it only
// while the block is idle, and the block itself does not enforce this. Values
// below two act as two. Reset sets the base to 2 and empties the block.
// Operation: a transaction walks D base-p digits, D being the digit count of
// the larger of n and m. Each digit is a restoring division of both values
// by the base at one bit per cycle, then two 64-bit products built from two
// passes of one (BASE_BITS+1) x 32 multiplier. When both values are zero the
// result is captured with no digit walk.
// One transaction is in flight at a time. The result sits in an output
// register, so the next transaction is accepted while it waits; if the
// receiver stalls, a finished walk holds until the register is free.
module base_digit_dominance_counter #(
  parameter int VALUE_BITS = 63,
  parameter int BASE_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  digit_base_wr_en,
  input  logic [BASE_BITS-1:0]  digit_base,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] query_value,
  input  logic [VALUE_BITS-1:0] bound_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [63:0]           dominated_count,
  output logic [62:0]           undominated_count,
  output logic                  query_dominated
);
  import bddc_pkg::*;

  bddc_cmd_t    cmd;
  bddc_status_t status;

  bddc_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bddc_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .BASE_BITS  (BASE_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .base_wr_en        (digit_base_wr_en),
    .base_wr_data      (digit_base),
    .query_value       (query_value),
    .bound_value       (bound_value),
    .cmd               (cmd),
    .status            (status),
    .dominated_count   (dominated_count),
    .undominated_count (undominated_count),
    .query_dominated   (query_dominated)
  );

endmodule

### verif/tb_base_digit_dominance_counter.sv
`timescale 1ns / 100ps

module tb_base_digit_dominance_counter;

  localparam int            LONG_HOLD = 3000;
  localparam logic [62:0]   VMAX      = '1;
  localparam logic [63:0]   TOP_BIT   = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] dominated;
    logic [62:0] undominated;
    logic        q_dom;
  } tally_t;

  typedef struct packed {
    logic [15:0] base;
    logic [62:0] query;
    logic [62:0] bound;
    logic        typed;
    tally_t      want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        digit_base_wr_en = 1'b0;
  logic [15:0] digit_base = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [62:0] query_value = 63'd0;
  logic [62:0] bound_value = 63'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] dominated_count;
  logic [62:0] undominated_count;
  logic        query_dominated;

  tally_t      pending_tallies[$];
  stim_row_t   dir_tab[$];
  logic        pend_typed = 1'b0;
  tally_t      pend_want = '0;
  logic [15:0] drv_base = 16'd2;
  logic [15:0] model_base = 16'd2;
  logic        quiet = 1'b0;
  logic        long_hold_req = 1'b0;
  logic        long_hold_taken = 1'b0;
  int          long_hold_cnt = 0;
  int          rx_gap = 0;
  int          err_count = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          base_writes = 0;

  base_digit_dominance_counter u_top (
    .clk               (clk),
    .rst               (rst),
    .digit_base_wr_en  (digit_base_wr_en),
    .digit_base        (digit_base),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .query_value       (query_value),
    .bound_value       (bound_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .dominated_count   (dominated_count),
    .undominated_count (undominated_count),
    .query_dominated   (query_dominated)
  );

  always #6 clk = ~clk;

  // digit walk from the least significant digit, all products mod 2^64
  function automatic tally_t count_dominated(input logic [62:0] n, input logic [62:0] m,
                                             input logic [15:0] base);
    tally_t      t;
    logic [63:0] radix, rq, rb, prod, cnt, nd, md, low;
    logic        viol;
    radix = (base < 16'd2) ? 64'd2 : {48'd0, base};
    rq    = {1'b0, n};
    rb    = {1'b0, m};
    prod  = 64'd1;
    cnt   = 64'd1;
    viol  = 1'b0;
    while (rq != 64'd0 || rb != 64'd0) begin
      nd = rq % radix;
      md = rb % radix;
      if (nd > md) begin
        cnt  = (md + 64'd1) * prod;
        viol = 1'b1;
      end else begin
        cnt = nd * prod + cnt;
      end
      prod = prod * (md + 64'd1);
      rq   = rq / radix;
      rb   = rb / radix;
    end
    low           = (n < m) ? {1'b0, n} : {1'b0, m};
    t.dominated   = cnt;
    t.undominated = low[62:0] + 63'd1 - cnt[62:0];
    t.q_dom       = ~viol;
    return t;
  endfunction

  function automatic stim_row_t row(input logic [15:0] b, input logic [62:0] n,
                                    input logic [62:0] m, input logic typed,
                                    input logic [63:0] dc, input logic [62:0] uc,
                                    input logic qd);
    stim_row_t r;
    r.base              = b;
    r.query             = n;
    r.bound             = m;
    r.typed             = typed;
    r.want.dominated    = dc;
    r.want.undominated  = uc;
    r.want.q_dom        = qd;
    return r;
  endfunction

  task automatic add_row(input stim_row_t r);
    dir_tab.insert(dir_tab.size(), r);
  endtask

  function automatic logic [62:0] rand_value();
    logic [63:0] r;
    int          w;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return VMAX;
      1:       return 63'd0;
      2, 3:    return r[62:0];
      default: begin
        w = $urandom_range(1, 62);
        return r[62:0] & ((63'd1 << w) - 63'd1);
      end
    endcase
  endfunction

  // value whose every digit is within the matching digit of m
  function automatic logic [62:0] digitwise_below(input logic [62:0] m, input logic [15:0] base);
    logic [63:0] radix, rb, scale, acc, md;
    radix = (base < 16'd2) ? 64'd2 : {48'd0, base};
    rb    = {1'b0, m};
    scale = 64'd1;
    acc   = 64'd0;
    while (rb != 64'd0) begin
      md    = rb % radix;
      acc   = acc + (64'($urandom) % (md + 64'd1)) * scale;
      scale = scale * radix;
      rb    = rb / radix;
    end
    return acc[62:0];
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic send_item(input logic [62:0] n, input logic [62:0] m, input logic typed,
                           input tally_t want);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    query_value <= n;
    bound_value <= m;
    in_valid    <= 1'b1;
    pend_typed  = typed;
    pend_want   = want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // sender stops until every outstanding result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_tallies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_base(input logic [15:0] b);
    drain();
    digit_base       <= b;
    digit_base_wr_en <= 1'b1;
    @(negedge clk);
    digit_base_wr_en <= 1'b0;
    drv_base = b;
    base_writes++;
  endtask

  // receiver: random stall bursts, one long hold-off, none in the quiet tail
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_hold_cnt > 0) begin
      out_ready     <= 1'b0;
      long_hold_cnt <= long_hold_cnt - 1;
    end else if (long_hold_req && !long_hold_taken) begin
      out_ready       <= 1'b0;
      long_hold_taken <= 1'b1;
      long_hold_cnt   <= LONG_HOLD - 1;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap    <= rx_gap - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      rx_gap    <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : scoreboard
    tally_t want;
    if (rst) begin
      model_base = 16'd2;
    end else begin
      if (digit_base_wr_en)
        model_base = digit_base;
      if (out_valid && out_ready) begin
        if (pending_tallies.size() == 0) begin
          flag_mismatch("result with nothing outstanding", dominated_count, 64'd0);
        end else begin
          want = pending_tallies.pop_front();
          results_seen++;
          if (dominated_count !== want.dominated)
            flag_mismatch("dominated_count", dominated_count, want.dominated);
          if (undominated_count !== want.undominated)
            flag_mismatch("undominated_count", {1'b0, undominated_count},
                          {1'b0, want.undominated});
          if (query_dominated !== want.q_dom)
            flag_mismatch("query_dominated", {63'd0, query_dominated}, {63'd0, want.q_dom});
        end
      end
      if (in_valid && in_ready)
        pending_tallies.insert(pending_tallies.size(),
                               pend_typed ? pend_want
                                          : count_dominated(query_value, bound_value,
                                                            model_base));
    end
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] b;
    logic [62:0] n, m;

    // base extremes, zero operands, query above bound, bases below two
    add_row(row(16'd2, 63'd0, 63'd0, 1'b1, 64'd1, 63'd0, 1'b1));
    add_row(row(16'd2, VMAX, VMAX, 1'b1, TOP_BIT, 63'd0, 1'b1));
    add_row(row(16'd2, VMAX, 63'd0, 1'b1, 64'd1, 63'd0, 1'b0));
    add_row(row(16'd2, 63'd0, VMAX, 1'b1, 64'd1, 63'd0, 1'b1));
    add_row(row(16'd2, 63'd1, 63'd0, 1'b1, 64'd1, 63'd0, 1'b0));
    add_row(row(16'd2, 63'd5, 63'd7, 1'b0, 64'd0, 63'd0, 1'b0));
    add_row(row(16'd2, VMAX, 63'd1 << 62, 1'b0, 64'd0, 63'd0, 1'b0));
    add_row(row(16'd2, 63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA,
                1'b0, 64'd0, 63'd0, 1'b0));
    add_row(row(16'd0, 63'd5, 63'd7, 1'b1, 64'd6, 63'd0, 1'b1));
    add_row(row(16'd1, 63'd3, 63'd1, 1'b1, 64'd2, 63'd0, 1'b0));
    add_row(row(16'd1, 63'd0, 63'd0, 1'b1, 64'd1, 63'd0, 1'b1));
    add_row(row(16'd10, 63'd9, 63'd10, 1'b1, 64'd1, 63'd9, 1'b0));
    add_row(row(16'd10, 63'd123456789, 63'd987654321, 1'b0, 64'd0, 63'd0, 1'b0));
    add_row(row(16'd10, 63'd999, 63'd99, 1'b0, 64'd0, 63'd0, 1'b0));
    add_row(row(16'd3, VMAX, VMAX, 1'b0, 64'd0, 63'd0, 1'b0));
    add_row(row(16'd3, 63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555,
                1'b0, 64'd0, 63'd0, 1'b0));
    add_row(row(16'hFFFF, VMAX, VMAX, 1'b0, 64'd0, 63'd0, 1'b0));
    add_row(row(16'hFFFF, 63'd65534, 63'd65534, 1'b0, 64'd0, 63'd0, 1'b0));
    add_row(row(16'hFFFF, 63'd65535, 63'd65534, 1'b0, 64'd0, 63'd0, 1'b0));
    add_row(row(16'hFFFF, VMAX, 63'd0, 1'b1, 64'd1, 63'd0, 1'b0));
    add_row(row(16'hFFFF, 63'd0, VMAX, 1'b1, 64'd1, 63'd0, 1'b1));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].base != drv_base)
        write_base(dir_tab[i].base);
      send_item(dir_tab[i].query, dir_tab[i].bound, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0:       b = 16'd2;
        1:       b = 16'd3;
        2:       b = 16'd10;
        3:       b = 16'd0;
        4:       b = 16'hFFFF;
        5:       b = 16'd1;
        6:       b = 16'($urandom);
        7:       b = 16'($urandom_range(2, 16));
        default: b = 16'd7;
      endcase
      write_base(b);
      // short walks here, so the long hold-off backs the block up to its input
      if (ph == 4)
        long_hold_req <= 1'b1;
      if (ph == 8)
        quiet <= 1'b1;
      for (int k = 0; k < 16; k++) begin
        if (ph == 2 && k == 8)
          drain();
        m = rand_value();
        case ($urandom_range(0, 9))
          0, 1, 2: n = rand_value();
          3, 4, 5: n = digitwise_below(m, drv_base);
          6:       n = m;
          7:       n = m + 63'($urandom_range(1, 20));
          8: begin
            n = rand_value();
            m = digitwise_below(n, drv_base);
          end
          default: begin
            n = rand_value();
            m = $urandom_range(0, 1) ? VMAX : 63'd0;
          end
        endcase
        send_item(n, m, 1'b0, '0);
      end
    end

    drain();
    repeat (40) @(negedge clk);

    $display("Covered %0d transactions (%0d directed) across %0d digit base writes,",
             items_sent, dir_tab.size(), base_writes);
    $display("including a %0d-cycle output stall; %0d results checked.",
             LONG_HOLD, results_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
